/* src/pica_pkg.sv */
// Package for the PI controller with back-calculation anti-windup.
// Holds the register map, the configuration and command types, and the FSM states.
// No dependencies.
`timescale 1ns / 1ps

package pica_pkg;

	localparam int unsigned DATA_W = 16;
	localparam int unsigned GAIN_W = 15;
	localparam int unsigned SHIFT_W = 4;
	localparam int unsigned ACC_W = 32;
	localparam int unsigned IDX_W = 4;

	// register indexes
	localparam logic [IDX_W-1:0] REG_REF_MIN = 4'd0;
	localparam logic [IDX_W-1:0] REG_REF_MAX = 4'd1;
	localparam logic [IDX_W-1:0] REG_OUT_MIN = 4'd2;
	localparam logic [IDX_W-1:0] REG_OUT_MAX = 4'd3;
	localparam logic [IDX_W-1:0] REG_KP_GAIN = 4'd4;
	localparam logic [IDX_W-1:0] REG_P_SHIFT = 4'd5;
	localparam logic [IDX_W-1:0] REG_KI_GAIN = 4'd6;
	localparam logic [IDX_W-1:0] REG_KC_GAIN = 4'd7;

	// upper clamp of the proportional term
	localparam logic signed [ACC_W-1:0] P_LIMIT = 32'sd32767;

	typedef struct packed {
		logic signed [DATA_W-1:0] ref_min;
		logic signed [DATA_W-1:0] ref_max;
		logic signed [DATA_W-1:0] out_min;
		logic signed [DATA_W-1:0] out_max;
		logic [GAIN_W-1:0] kp_gain;
		logic [SHIFT_W-1:0] p_shift;
		logic [GAIN_W-1:0] ki_gain;
		logic [GAIN_W-1:0] kc_gain;
	} cfg_t;

	typedef enum logic [1:0] {
		MUL_KP,
		MUL_KI,
		MUL_KC
	} mul_sel_t;

	typedef struct packed {
		logic load_err;   // capture the error of an accepted beat
		logic mul_en;     // register a product
		mul_sel_t mul_sel;
		logic load_p;     // register the clamped proportional term
		logic sat_en;     // saturate, form excess, add ki*err
		logic upd_en;     // subtract kc*excess, load the output register
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_P,
		ST_MUL_I,
		ST_SAT,
		ST_MUL_C,
		ST_UPD
	} state_t;

endpackage

/* src/pi_controller_antiwindup.sv */
// PI controller with back-calculation anti-windup, top level.
// An accepted input beat steps through the kp, ki and kc products of the single shared
// 15x32 multiplier, a saturation step and an update step that loads the drive register;
// a new sample is taken only back in idle, and the update step waits while a held result is stalled.
// Reset: async, active low; config, state and output valid to their reset values, integrator to zero.
`timescale 1ns / 1ps

module pi_controller_antiwindup (
	input  logic clk,
	input  logic arst_n,
	// sample input channel
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [pica_pkg::DATA_W-1:0] reference,
	input  logic signed [pica_pkg::DATA_W-1:0] measurement,
	// drive output channel
	output logic out_valid,
	input  logic out_stall,
	output logic signed [pica_pkg::DATA_W-1:0] drive,
	// configuration write channel
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [pica_pkg::IDX_W-1:0] cfg_index,
	input  logic [pica_pkg::DATA_W-1:0] cfg_data
);

	pica_pkg::cfg_t cfg;
	pica_pkg::cmd_t cmd;

	// registers take a write in any cycle; software writes them only while idle (the block does not enforce it)
	assign cfg_ready = 1'b1;

	pica_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// sequencer: idle -> kp mult -> ki mult + p clamp -> saturate -> kc mult -> update
	pica_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	// datapath holds the error, the shared product register, the integrator and
	// the output register that parts the result from the next sample
	pica_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.cmd         (cmd),
		.reference   (reference),
		.measurement (measurement),
		.drive       (drive)
	);

endmodule

/* src/pica_regs.sv */
// Configuration register file of the PI controller.
// Depends on pica_pkg.
`timescale 1ns / 1ps

module pica_regs (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	input  logic [pica_pkg::IDX_W-1:0] cfg_index,
	input  logic [pica_pkg::DATA_W-1:0] cfg_data,
	output pica_pkg::cfg_t cfg
);

	pica_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ref_min <= 16'sd0;
			cfg_q.ref_max <= 16'sd32767;
			cfg_q.out_min <= 16'sd0;
			cfg_q.out_max <= 16'sd32767;
			cfg_q.kp_gain <= '0;
			cfg_q.p_shift <= '0;
			cfg_q.ki_gain <= '0;
			cfg_q.kc_gain <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				pica_pkg::REG_REF_MIN: cfg_q.ref_min <= cfg_data;
				pica_pkg::REG_REF_MAX: cfg_q.ref_max <= cfg_data;
				pica_pkg::REG_OUT_MIN: cfg_q.out_min <= cfg_data;
				pica_pkg::REG_OUT_MAX: cfg_q.out_max <= cfg_data;
				pica_pkg::REG_KP_GAIN: cfg_q.kp_gain <= cfg_data[pica_pkg::GAIN_W-1:0];
				pica_pkg::REG_P_SHIFT: cfg_q.p_shift <= cfg_data[pica_pkg::SHIFT_W-1:0];
				pica_pkg::REG_KI_GAIN: cfg_q.ki_gain <= cfg_data[pica_pkg::GAIN_W-1:0];
				pica_pkg::REG_KC_GAIN: cfg_q.kc_gain <= cfg_data[pica_pkg::GAIN_W-1:0];
				default: ; // unmapped index, write dropped
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* src/pica_dp.sv */
// Datapath of the PI controller: error, shared multiplier, saturation, integrator.
// Depends on pica_pkg; driven by the command struct from pica_ctrl.
`timescale 1ns / 1ps

module pica_dp (
	input  logic clk,
	input  logic arst_n,
	input  pica_pkg::cfg_t cfg,
	input  pica_pkg::cmd_t cmd,
	input  logic signed [pica_pkg::DATA_W-1:0] reference,
	input  logic signed [pica_pkg::DATA_W-1:0] measurement,
	output logic signed [pica_pkg::DATA_W-1:0] drive
);

	logic signed [15:0] r_clamp;
	logic signed [15:0] err_next;
	logic signed [15:0] err_q;

	logic [14:0] mul_a;
	logic [31:0] mul_b;
	logic [46:0] mul_full;
	logic [31:0] prod_q;

	logic signed [16:0] p_base;
	logic signed [31:0] p_wide;
	logic signed [31:0] p_shl;
	logic signed [31:0] p_sat;
	logic signed [31:0] p_q;

	logic signed [16:0] i_term;
	logic signed [32:0] u_sum;
	logic signed [32:0] omin_x;
	logic signed [32:0] omax_x;
	logic signed [15:0] drv_next;
	logic [31:0] excess_next;
	logic [31:0] excess_q;
	logic signed [15:0] drv_q;
	logic signed [15:0] drive_q;
	logic [31:0] acc_q;

	// reference clamp, max first so ref_min wins when limits cross
	always_comb begin
		r_clamp = reference;
		if (r_clamp >= cfg.ref_max)
			r_clamp = cfg.ref_max;
		if (r_clamp <= cfg.ref_min)
			r_clamp = cfg.ref_min;
		err_next = r_clamp - measurement;
	end

	// shared multiplier, low 32 bits are exact mod 2^32 for every use
	always_comb begin
		unique case (cmd.mul_sel)
			pica_pkg::MUL_KP: begin
				mul_a = cfg.kp_gain;
				mul_b = {{16{err_q[15]}}, err_q};
			end
			pica_pkg::MUL_KI: begin
				mul_a = cfg.ki_gain;
				mul_b = {{16{err_q[15]}}, err_q};
			end
			pica_pkg::MUL_KC: begin
				mul_a = cfg.kc_gain;
				mul_b = excess_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		mul_full = {32'd0, mul_a} * {15'd0, mul_b};
	end

	// proportional term: floor shift, gain exponent, upper clamp
	always_comb begin
		p_base = signed'(prod_q[31:15]);
		p_wide = {{15{p_base[16]}}, p_base};
		p_shl = p_wide <<< cfg.p_shift;
		p_sat = (p_shl >= pica_pkg::P_LIMIT) ? pica_pkg::P_LIMIT : p_shl;
	end

	// sum and output saturation
	always_comb begin
		i_term = signed'(acc_q[31:15]);
		u_sum = {p_q[31], p_q} + {{16{i_term[16]}}, i_term};
		omin_x = {{17{cfg.out_min[15]}}, cfg.out_min};
		omax_x = {{17{cfg.out_max[15]}}, cfg.out_max};
		if (u_sum > omax_x)
			drv_next = cfg.out_max;
		else if (u_sum < omin_x)
			drv_next = cfg.out_min;
		else
			drv_next = u_sum[15:0];
		excess_next = u_sum[31:0] - {{16{drv_next[15]}}, drv_next};
	end

	always_ff @(posedge clk) begin
		if (cmd.load_err)
			err_q <= err_next;
		if (cmd.mul_en)
			prod_q <= mul_full[31:0];
		if (cmd.load_p)
			p_q <= p_sat;
		if (cmd.sat_en) begin
			excess_q <= excess_next;
			drv_q <= drv_next;
		end
		if (cmd.upd_en)
			drive_q <= drv_q;
	end

	// integrator: +ki*err at saturation, -kc*excess at update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (cmd.sat_en) begin
			acc_q <= acc_q + prod_q;
		end else if (cmd.upd_en) begin
			acc_q <= acc_q - prod_q;
		end
	end

	assign drive = drive_q;

endmodule

/* src/pica_ctrl.sv */
// Sequencer of the PI controller: steps one sample through the datapath and
// owns the output valid flag. Depends on pica_pkg.
`timescale 1ns / 1ps

module pica_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	output pica_pkg::cmd_t cmd
);

	pica_pkg::state_t state_q;
	pica_pkg::state_t state_next;
	logic out_valid_q;
	logic out_free;
	logic in_take;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != pica_pkg::ST_IDLE);
	assign in_take = in_valid && !in_stall;

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			pica_pkg::ST_IDLE: begin
				if (in_valid)
					state_next = pica_pkg::ST_MUL_P;
			end
			pica_pkg::ST_MUL_P: state_next = pica_pkg::ST_MUL_I;
			pica_pkg::ST_MUL_I: state_next = pica_pkg::ST_SAT;
			pica_pkg::ST_SAT:   state_next = pica_pkg::ST_MUL_C;
			pica_pkg::ST_MUL_C: state_next = pica_pkg::ST_UPD;
			pica_pkg::ST_UPD: begin
				if (out_free)
					state_next = pica_pkg::ST_IDLE;
			end
			default: state_next = pica_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.mul_sel = pica_pkg::MUL_KP;
		unique case (state_q)
			pica_pkg::ST_IDLE: cmd.load_err = in_valid;
			pica_pkg::ST_MUL_P: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = pica_pkg::MUL_KP;
			end
			pica_pkg::ST_MUL_I: begin
				cmd.load_p = 1'b1;
				cmd.mul_en = 1'b1;
				cmd.mul_sel = pica_pkg::MUL_KI;
			end
			pica_pkg::ST_SAT: cmd.sat_en = 1'b1;
			pica_pkg::ST_MUL_C: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = pica_pkg::MUL_KC;
			end
			pica_pkg::ST_UPD: cmd.upd_en = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pica_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.upd_en) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	a_take_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> state_q == pica_pkg::ST_MUL_P)
		else $error("accepted beat did not start the multiply sequence");

	a_valid_from_upd: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == pica_pkg::ST_UPD)
		else $error("output valid raised outside the update step");

	a_upd_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pica_pkg::ST_UPD && !out_free) |=> state_q == pica_pkg::ST_UPD)
		else $error("update step left while output register busy");

	a_single_update: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.upd_en |=> !cmd.upd_en)
		else $error("integrator updated twice for one sample");

endmodule
